// ----- rtl/wrms_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the windowed RMS dB meter.
package wrms_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WINDOW_MAX_DEF  = 8192;
  localparam int QUEUE_DEPTH     = 2;

  localparam int MIN_DB_W = 17;
  localparam int MAX_DB_W = 15;
  localparam int LEVEL_W  = 17;
  localparam int CFG_W    = 17;

  localparam logic signed [MIN_DB_W-1:0] MIN_DB_RST = -17'sd24576;
  localparam logic signed [MAX_DB_W-1:0] MAX_DB_RST = 15'sd0;

  // log2 fraction bits and 10*log10(2) in Q.16
  localparam int FRAC_BITS         = 16;
  localparam int MANT_W            = 31;
  localparam int DB_PER_OCTAVE_Q16 = 197283;

  typedef enum logic [0:0] {
    CFG_MIN_DB = 1'b0,
    CFG_MAX_DB = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [MIN_DB_W-1:0] min_db;
    logic signed [MAX_DB_W-1:0] max_db;
  } db_limits_t;

endpackage

// ----- rtl/wrms_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: one audio sample word with window framing.
interface wrms_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          has_sample;
  logic                          window_last;

  modport source (output valid, output sample, output has_sample, output window_last,
                  input ready);
  modport sink   (input valid, input sample, input has_sample, input window_last,
                  output ready);
endinterface

// ----- rtl/wrms_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: one level word per closed window.
interface wrms_out_if;
  import wrms_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level_db;
  logic                      window_empty;

  modport source (output valid, output level_db, output window_empty, input ready);
  modport sink   (input valid, input level_db, input window_empty, output ready);
endinterface

// ----- rtl/windowed_rms_db_meter.sv -----
`timescale 1ns / 1ps
// Windowed RMS level meter: top level with configuration registers.
//
// in_ch carries one sample word per transfer; has_sample=0 adds nothing and
// window_last=1 closes the window after that word. For each closed window one
// word leaves on out_ch: the RMS level in signed Q8.8 dBFS clamped to
// [min_db, max_db], with window_empty set when the window held no samples.
// The front end takes one word per cycle while the two-entry window queue has
// room. Each closed window then runs through the back end: a one-bit-per-cycle
// normalizing shifter and a 16-step squaring loop, shared by the sum of squares
// and the count, then subtract, multiply and clamp. Empty or silent windows
// skip these steps and go straight to the output stage. The back end takes a
// new window from the queue only when idle, so window rate is set by that loop.
// The result sits in an output register; while out_ch stalls, the back end
// holds its next result and the queue fills, then in_ch deasserts ready.
// Reset clears the accumulators, queue and output valid and loads min_db =
// -96 dB, max_db = 0 dB. cfg writes take effect on the next edge.
module windowed_rms_db_meter #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_MAX  = wrms_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  wrms_in_if.sink                       in_ch,
  wrms_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  wrms_pkg::cfg_idx_t            cfg_index,
  input  logic [wrms_pkg::CFG_W-1:0]    cfg_data
);
  import wrms_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int QW    = SUM_W + CNT_W;

  logic signed [MIN_DB_W-1:0] min_db_r;
  logic signed [MAX_DB_W-1:0] max_db_r;
  db_limits_t                 limits;

  logic             push, q_full, q_pop, q_valid;
  logic [SUM_W-1:0] push_sum, q_sum;
  logic [CNT_W-1:0] push_cnt, q_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_db_r <= MIN_DB_RST;
      max_db_r <= MAX_DB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DB: min_db_r <= cfg_data[MIN_DB_W-1:0];
        CFG_MAX_DB: max_db_r <= cfg_data[MAX_DB_W-1:0];
        default: ;
      endcase
    end
  end

  assign limits.min_db = min_db_r;
  assign limits.max_db = max_db_r;

  wrms_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_MAX  (WINDOW_MAX),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_sum (push_sum),
    .push_cnt (push_cnt),
    .q_full   (q_full)
  );

  wrms_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_sum, push_cnt}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  ({q_sum, q_cnt})
  );

  wrms_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .limits  (limits),
    .q_valid (q_valid),
    .q_sum   (q_sum),
    .q_cnt   (q_cnt),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/wrms_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts sample words, accumulates sum of squares and count per window.
module wrms_front #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_MAX  = wrms_pkg::WINDOW_MAX_DEF,
  parameter int CNT_W       = $clog2(WINDOW_MAX + 1),
  parameter int SUM_W       = 2 * SAMPLE_BITS - 2 + CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  wrms_in_if.sink          in_ch,
  output logic             push,
  output logic [SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0] push_cnt,
  input  logic             q_full
);
  import wrms_pkg::*;

  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic                     acc;
  logic                     take;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  // samples past the window limit are dropped
  assign take        = acc && in_ch.has_sample && (cnt_r < CNT_W'(WINDOW_MAX));

  always_comb begin
    // -full scale maps to 2^(SAMPLE_BITS-1), which still fits unsigned
    mag = in_ch.sample[SAMPLE_BITS-1] ? (~unsigned'(in_ch.sample) + 1'b1)
                                      : unsigned'(in_ch.sample);
    sq  = mag * mag;
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (take) begin
      sum_nxt = sum_r + SUM_W'(sq);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign push     = acc && in_ch.window_last;
  assign push_sum = sum_nxt;
  assign push_cnt = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (push) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/wrms_queue.sv -----
`timescale 1ns / 1ps
// Small register FIFO carrying closed windows from front end to back end.
module wrms_queue #(
  parameter int WIDTH = 58,
  parameter int DEPTH = wrms_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import wrms_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/wrms_back.sv -----
`timescale 1ns / 1ps
// Back end: iterative log2 of sum and count, dB scaling, clamping and result register.
module wrms_back #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = 14,
  parameter int SUM_W       = 44
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wrms_pkg::db_limits_t limits,
  input  logic                 q_valid,
  input  logic [SUM_W-1:0]     q_sum,
  input  logic [CNT_W-1:0]     q_cnt,
  output logic                 q_pop,
  wrms_out_if.source           out_ch
);
  import wrms_pkg::*;

  localparam int NW     = (SUM_W > MANT_W) ? SUM_W : MANT_W;
  localparam int PW     = $clog2(NW);
  localparam int LOG_W  = PW + FRAC_BITS;
  localparam int LW     = LOG_W + 2;
  localparam int PROD_W = LW + 19;
  localparam int LV_W   = PROD_W - 24;
  localparam int CMP_W  = (LV_W > 18) ? LV_W : 18;
  localparam int IT_W   = $clog2(FRAC_BITS);

  localparam logic signed [LW-1:0]     FS_OFS = LW'((2 * (SAMPLE_BITS - 1)) * 65536);
  localparam logic signed [PROD_W-1:0] DB_K   = PROD_W'(DB_PER_OCTAVE_Q16);
  localparam logic signed [PROD_W-1:0] RND    = PROD_W'(64'd1 << 23);

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_FRAC, S_DIFF, S_MUL, S_CLAMP, S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [NW-1:0]              nrm_r, nrm_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [MANT_W-1:0]          mant_r, mant_nxt;
  logic [FRAC_BITS-1:0]       frac_r, frac_nxt;
  logic [IT_W-1:0]            it_r, it_nxt;
  logic                       second_r, second_nxt;
  logic [LOG_W-1:0]           log_sum_r, log_sum_nxt;
  logic signed [LW-1:0]       l_r, l_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [LEVEL_W-1:0]  res_r, res_nxt;
  logic                       res_empty_r, res_empty_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [LEVEL_W-1:0]  out_level_r, out_level_nxt;
  logic                       out_empty_r, out_empty_nxt;

  logic [2*MANT_W-1:0]        sq;
  logic [LOG_W-1:0]           log_now;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [LV_W-1:0]     lv;
  logic signed [CMP_W-1:0]    lv_c, mn_c, mx_c;
  logic                       out_free;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.level_db     = out_level_r;
  assign out_ch.window_empty = out_empty_r;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign q_pop               = (state_r == S_IDLE) && q_valid;

  always_comb begin
    sq      = mant_r * mant_r;
    rnd     = prod_r + RND;
    lv      = rnd[PROD_W-1:24];
    lv_c    = CMP_W'(lv);
    mn_c    = CMP_W'(limits.min_db);
    mx_c    = CMP_W'(limits.max_db);
    log_now = {pos_r, frac_r};
    if (lv_c > mx_c) lv_c = mx_c;
    if (lv_c < mn_c) lv_c = mn_c;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    nrm_nxt       = nrm_r;
    pos_nxt       = pos_r;
    mant_nxt      = mant_r;
    frac_nxt      = frac_r;
    it_nxt        = it_r;
    second_nxt    = second_r;
    log_sum_nxt   = log_sum_r;
    l_nxt         = l_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    res_empty_nxt = res_empty_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_level_nxt = out_level_r;
    out_empty_nxt = out_empty_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cnt_nxt    = q_cnt;
          nrm_nxt    = NW'(q_sum);
          pos_nxt    = PW'(NW - 1);
          second_nxt = 1'b0;
          if (q_cnt == '0) begin
            res_nxt       = LEVEL_W'(limits.min_db);
            res_empty_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end else if (q_sum == '0) begin
            // clamp of min_db against max_db always lands on min_db
            res_nxt       = LEVEL_W'(limits.min_db);
            res_empty_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        // one bit per cycle until the leading one reaches the top
        if (nrm_r[NW-1]) begin
          mant_nxt  = nrm_r[NW-1 -: MANT_W];
          frac_nxt  = '0;
          it_nxt    = '0;
          state_nxt = S_FRAC;
        end else begin
          nrm_nxt = {nrm_r[NW-2:0], 1'b0};
          pos_nxt = pos_r - 1'b1;
        end
      end
      S_FRAC: begin
        if (sq[2*MANT_W-1]) begin
          mant_nxt = sq[2*MANT_W-1 -: MANT_W];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          mant_nxt = sq[2*MANT_W-2 -: MANT_W];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == IT_W'(FRAC_BITS - 1)) begin
          if (!second_r) begin
            log_sum_nxt = {pos_r, frac_nxt};
            nrm_nxt     = NW'(cnt_r);
            pos_nxt     = PW'(NW - 1);
            second_nxt  = 1'b1;
            state_nxt   = S_NORM;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        l_nxt     = $signed({2'b00, log_sum_r}) - $signed({2'b00, log_now}) - FS_OFS;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(l_r) * DB_K;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        res_nxt       = lv_c[LEVEL_W-1:0];
        res_empty_nxt = 1'b0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = res_r;
          out_empty_nxt = res_empty_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    nrm_r       <= nrm_nxt;
    pos_r       <= pos_nxt;
    mant_r      <= mant_nxt;
    frac_r      <= frac_nxt;
    it_r        <= it_nxt;
    second_r    <= second_nxt;
    log_sum_r   <= log_sum_nxt;
    l_r         <= l_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    res_empty_r <= res_empty_nxt;
    out_level_r <= out_level_nxt;
    out_empty_r <= out_empty_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
